### hw/rtl/spct_pkg.sv
// Package with widths, the pair mode code and the pipeline stage types of the collision test.
package spct_pkg;

    // Field widths of one shape.
    localparam int COORD_W = 24;
    localparam int SIZE_W  = 23;

    // Internal widths, all in doubled units.
    localparam int MAG_W = COORD_W + 1;   // |2 * (center_a - center_b)|
    localparam int EXT_W = SIZE_W + 1;    // sum of two sizes
    localparam int RAD_W = SIZE_W + 2;    // doubled radius or doubled radius sum
    localparam int SQ_W  = 2 * MAG_W;     // square of a gap or of a radius
    localparam int SUM_W = SQ_W + 1;      // sum of two squares

    // Which pair of shape kinds the request holds.
    typedef enum logic [1:0] {
        MODE_CC,    // circle and circle
        MODE_RR,    // rectangle and rectangle
        MODE_CR     // circle and rectangle, either order
    } t_mode;

    // One shape as it arrives.
    typedef struct packed {
        logic                      rect;
        logic signed [COORD_W-1:0] cx;
        logic signed [COORD_W-1:0] cy;
        logic        [SIZE_W-1:0]  major;
        logic        [SIZE_W-1:0]  minor;
    } t_shape;

    // Center distances and the extents they are tested against.
    typedef struct packed {
        t_mode            mode;
        logic [MAG_W-1:0] mag_x;
        logic [MAG_W-1:0] mag_y;
        logic [EXT_W-1:0] ext_x;
        logic [EXT_W-1:0] ext_y;
        logic [RAD_W-1:0] rad;
    } t_s2;

    // Gaps to be squared, plus the finished rectangle pair answer.
    typedef struct packed {
        t_mode            mode;
        logic [MAG_W-1:0] gap_x;
        logic [MAG_W-1:0] gap_y;
        logic [RAD_W-1:0] rad;
        logic             rr_hit;
    } t_s3;

    // Squares ready for the final sum and compare.
    typedef struct packed {
        t_mode           mode;
        logic [SQ_W-1:0] sq_x;
        logic [SQ_W-1:0] sq_y;
        logic [SQ_W-1:0] sq_r;
        logic            rr_hit;
    } t_s4;

endpackage

### hw/rtl/shape_pair_collision_test_core.sv
// Overlap test for a pair of 2D shapes, each a circle or an axis-aligned rectangle.
// A request's result reaches o_valid through the input, difference, gap, square and compare registers.
// Throughput: one request per cycle; the difference, gap, square and compare stages each
// hold one request and all move together whenever the result register can take a new value.
// Reset: i_rst_n is synchronous and active low; it clears every stage valid bit and o_valid.
// The datapath registers are not reset.
module shape_pair_collision_test_core (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_ready,
    input  logic                               i_a_kind,
    input  logic signed [spct_pkg::COORD_W-1:0] i_a_center_x,
    input  logic signed [spct_pkg::COORD_W-1:0] i_a_center_y,
    input  logic        [spct_pkg::SIZE_W-1:0]  i_a_size_major,
    input  logic        [spct_pkg::SIZE_W-1:0]  i_a_size_minor,
    input  logic                               i_b_kind,
    input  logic signed [spct_pkg::COORD_W-1:0] i_b_center_x,
    input  logic signed [spct_pkg::COORD_W-1:0] i_b_center_y,
    input  logic        [spct_pkg::SIZE_W-1:0]  i_b_size_major,
    input  logic        [spct_pkg::SIZE_W-1:0]  i_b_size_minor,
    output logic                               o_valid,
    input  logic                               i_ready,
    output logic                               o_overlap
);
    import spct_pkg::*;

    logic   w_adv;
    logic   r_s1_valid, r_s2_valid, r_s3_valid, r_s4_valid;
    t_shape r_s1_a, r_s1_b;
    t_s2    r_s2, n_s2;
    t_s3    r_s3, n_s3;
    t_s4    r_s4, n_s4;
    logic   r_overlap, n_overlap;

    logic signed [MAG_W-1:0] w_dx, w_dy, w_ax, w_ay;
    t_shape                  w_circ, w_rect;
    logic [EXT_W-1:0]        w_rsum;
    logic [SUM_W-1:0]        w_dist;

    // The whole pipeline moves unless a finished result is held by the consumer.
    assign w_adv   = !o_valid || i_ready;
    assign o_ready = w_adv;

    // Stage valid bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_s3_valid <= 1'b0;
            r_s4_valid <= 1'b0;
            o_valid    <= 1'b0;
        end else if (w_adv) begin
            r_s1_valid <= i_valid;
            r_s2_valid <= r_s1_valid;
            r_s3_valid <= r_s2_valid;
            r_s4_valid <= r_s3_valid;
            o_valid    <= r_s4_valid;
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s1_a    <= '{i_a_kind, i_a_center_x, i_a_center_y, i_a_size_major,
                           i_a_size_minor};
            r_s1_b    <= '{i_b_kind, i_b_center_x, i_b_center_y, i_b_size_major,
                           i_b_size_minor};
            r_s2      <= n_s2;
            r_s3      <= n_s3;
            r_s4      <= n_s4;
            r_overlap <= n_overlap;
        end
    end

    // Stage two: pair mode, doubled center distances, extents and radius.
    always_comb begin
        w_dx   = MAG_W'(r_s1_a.cx) - MAG_W'(r_s1_b.cx);
        w_dy   = MAG_W'(r_s1_a.cy) - MAG_W'(r_s1_b.cy);
        w_ax   = w_dx[MAG_W-1] ? -w_dx : w_dx;
        w_ay   = w_dy[MAG_W-1] ? -w_dy : w_dy;
        w_circ = r_s1_a.rect ? r_s1_b : r_s1_a;
        w_rect = r_s1_a.rect ? r_s1_a : r_s1_b;
        w_rsum = {1'b0, r_s1_a.major} + {1'b0, r_s1_b.major};

        n_s2.mag_x = {w_ax[MAG_W-2:0], 1'b0};
        n_s2.mag_y = {w_ay[MAG_W-2:0], 1'b0};
        case ({r_s1_a.rect, r_s1_b.rect})
            2'b00: begin
                n_s2.mode  = MODE_CC;
                n_s2.ext_x = '0;
                n_s2.ext_y = '0;
                n_s2.rad   = {w_rsum, 1'b0};
            end
            2'b11: begin
                n_s2.mode  = MODE_RR;
                n_s2.ext_x = w_rsum;
                n_s2.ext_y = {1'b0, r_s1_a.minor} + {1'b0, r_s1_b.minor};
                n_s2.rad   = '0;
            end
            default: begin
                n_s2.mode  = MODE_CR;
                n_s2.ext_x = {1'b0, w_rect.major};
                n_s2.ext_y = {1'b0, w_rect.minor};
                n_s2.rad   = {1'b0, w_circ.major, 1'b0};
            end
        endcase
    end

    // Stage three: circle-to-rectangle gaps (other pairs pass the distances on), and the rectangle test.
    always_comb begin
        n_s3.mode   = r_s2.mode;
        n_s3.rad    = r_s2.rad;
        n_s3.rr_hit = (r_s2.mag_x < MAG_W'(r_s2.ext_x)) && (r_s2.mag_y < MAG_W'(r_s2.ext_y));
        case (r_s2.mode)
            MODE_CR: begin
                n_s3.gap_x = (r_s2.mag_x > MAG_W'(r_s2.ext_x)) ?
                             r_s2.mag_x - MAG_W'(r_s2.ext_x) : '0;
                n_s3.gap_y = (r_s2.mag_y > MAG_W'(r_s2.ext_y)) ?
                             r_s2.mag_y - MAG_W'(r_s2.ext_y) : '0;
            end
            default: begin
                n_s3.gap_x = r_s2.mag_x;
                n_s3.gap_y = r_s2.mag_y;
            end
        endcase
    end

    // Stage four: squares of the gaps and of the radius.
    always_comb begin
        n_s4.mode   = r_s3.mode;
        n_s4.rr_hit = r_s3.rr_hit;
        n_s4.sq_x   = SQ_W'(r_s3.gap_x) * SQ_W'(r_s3.gap_x);
        n_s4.sq_y   = SQ_W'(r_s3.gap_y) * SQ_W'(r_s3.gap_y);
        n_s4.sq_r   = SQ_W'(r_s3.rad) * SQ_W'(r_s3.rad);
    end

    // Final stage: squared distance strictly below squared radius, or the rectangle test for a rectangle pair.
    always_comb begin
        w_dist = SUM_W'(r_s4.sq_x) + SUM_W'(r_s4.sq_y);
        case (r_s4.mode)
            MODE_RR: n_overlap = r_s4.rr_hit;
            default: n_overlap = w_dist < SUM_W'(r_s4.sq_r);
        endcase
    end

    assign o_overlap = r_overlap;

`ifndef SYNTHESIS
    // An accepted request enters the first stage.
    a_accept_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> r_s1_valid)
        else $error("accepted request did not enter the pipeline");

    // A stall freezes every stage valid bit.
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_adv |=> ($stable(r_s1_valid) && $stable(r_s2_valid) && $stable(r_s3_valid)
                    && $stable(r_s4_valid)))
        else $error("pipeline moved during a stall");

    // A new result only comes from the last stage.
    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(r_s4_valid))
        else $error("result appeared without a request in the last stage");

    // In a circle and rectangle pair the gap never exceeds the center distance.
    a_gap_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s2_valid && r_s2.mode == MODE_CR) |-> (n_s3.gap_x <= r_s2.mag_x
                                                   && n_s3.gap_y <= r_s2.mag_y))
        else $error("gap larger than center distance");
`endif

endmodule
